/* rtl/rle_shadow_pixel_darkener_macros.svh */
// Assertion macros shared by the checker of the shadow pixel darkener.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef RLE_SHADOW_PIXEL_DARKENER_MACROS_SVH
`define RLE_SHADOW_PIXEL_DARKENER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define RSPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rspd assertion failed");

// Next-cycle implication, disabled while reset is low
`define RSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rspd assertion failed");

`endif

/* rtl/rspd_pkg.sv */
// Shared types, constants and helpers of the shadow pixel darkener.
// No dependencies; imported by every module of the block but rspd_ram.
`default_nettype none

package rspd_pkg;

  localparam int PAIR_DEPTH  = 64;
  localparam int PAIR_PTR_W  = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int PAIR_FILL_W = $clog2(PAIR_DEPTH + 1);
  localparam int MAX_WIDTH   = 4096;
  localparam int WIDTH_W     = 13;
  localparam int COL_W       = 12;
  localparam int CNT_W       = 12;
  localparam int PAIR_W      = 2 * CNT_W;
  localparam int PIX_W       = 16;
  localparam int PCOUNT_W    = 7;
  localparam int IN_DATA_W   = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_HEADER     = 2'd0,
    OP_PAIR       = 2'd1,
    OP_EMPTY_PAIR = 2'd2,
    OP_PIXEL      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_BLACK = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_BLEND = 2'd2,
    MODE_PASS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DARK_MODE    = 2'd0,
    REG_DARK_SHIFT   = 2'd1,
    REG_SHADOW_ALPHA = 2'd2,
    REG_LINE_WIDTH   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         dark_mode;
    logic [2:0]         dark_shift;
    logic [7:0]         shadow_alpha;
    logic [WIDTH_W-1:0] line_width;
  } cfg_t;

  // Queue entry: pair payload is {trans, shadow}, others use the low bits
  typedef struct packed {
    op_t               op;
    logic [PAIR_W-1:0] payload;
  } qent_t;

  localparam logic [2:0]         MAX_SHIFT     = 3'd4;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL = WIDTH_W'(MAX_WIDTH);

  // Per-shift mask that keeps channel bits from bleeding into a neighbor
  function automatic logic [PIX_W-1:0] shift_mask(input logic [2:0] s);
    logic [PIX_W-1:0] m;
    case (s)
      3'd0:    m = 16'hFFFF;
      3'd1:    m = 16'h7BEF;
      3'd2:    m = 16'h39E7;
      3'd3:    m = 16'h18E3;
      default: m = 16'h0861;
    endcase
    return m;
  endfunction

  // Wrap a store pointer
  function automatic logic [PAIR_PTR_W-1:0] ptr_inc(input logic [PAIR_PTR_W-1:0] p);
    logic [PAIR_PTR_W-1:0] n;
    if (p == PAIR_PTR_W'(PAIR_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/rspd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the run pair store.
`default_nettype none

module rspd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/rspd_front.sv */
// Front end: accepts input requests and classifies them into queue entries.
// Depends on rspd_pkg; feeds rspd_queue.
`default_nettype none

module rspd_front
  import rspd_pkg::*;
(
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]           in_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output qent_t                     q_entry
);

  logic [PCOUNT_W-1:0] pair_count;
  logic [CNT_W-1:0]    trans_count;
  logic [CNT_W-1:0]    shadow_count;
  logic [PIX_W-1:0]    dest_pixel;
  logic                accept;

  assign pair_count   = in_tdata[6:0];
  assign trans_count  = in_tdata[18:7];
  assign shadow_count = in_tdata[30:19];
  assign dest_pixel   = in_tdata[46:31];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify; kind three is taken and dropped
  always_comb begin
    q_push          = 1'b0;
    q_entry.op      = OP_HEADER;
    q_entry.payload = '0;
    unique case (kind_t'(in_tuser))
      KIND_HEADER: begin
        q_push          = accept;
        q_entry.op      = OP_HEADER;
        q_entry.payload = PAIR_W'(pair_count);
      end
      KIND_PAIR: begin
        q_push          = accept;
        q_entry.op      = ((trans_count == '0) && (shadow_count == '0)) ?
                          OP_EMPTY_PAIR : OP_PAIR;
        q_entry.payload = {trans_count, shadow_count};
      end
      KIND_PIXEL: begin
        q_push          = accept;
        q_entry.op      = OP_PIXEL;
        q_entry.payload = PAIR_W'(dest_pixel);
      end
      KIND_NONE: begin
        q_push = 1'b0;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rspd_queue.sv */
// Short queue of classified requests between front end and back end.
// Depends on rspd_pkg.
`default_nettype none

module rspd_queue
  import rspd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  qent_t      push_entry,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output qent_t      head_entry
);

  qent_t              slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/rspd_back.sv */
// Back end: keeps the run pair store and run counters, darkens pixels.
// Depends on rspd_pkg and rspd_ram; drains rspd_queue.
`default_nettype none

module rspd_back
  import rspd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  wire logic              q_valid,
  input  qent_t                  q_entry,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [PIX_W-1:0]       out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [PAIR_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PAIR_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PAIR_FILL_W-1:0] fill_r, fill_nxt;
  logic [PCOUNT_W-1:0]    expect_r, expect_nxt;
  logic [CNT_W-1:0]       skip_r, skip_nxt;
  logic [CNT_W-1:0]       shade_r, shade_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [PAIR_W-1:0]      head_r, head_nxt;
  logic                   byp_r;
  logic [PAIR_W-1:0]      byp_data_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]       out_pixel_r, out_pixel_nxt;
  logic                   out_shadow_r, out_shadow_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   ram_we;
  logic [PAIR_PTR_W-1:0]  ram_raddr;
  logic [PAIR_W-1:0]      ram_rdata;
  logic [PAIR_W-1:0]      next_pair;
  logic                   out_free;
  logic                   take;
  logic [WIDTH_W-1:0]     width_eff;
  logic [CNT_W-1:0]       skip_cur;
  logic [CNT_W-1:0]       shade_cur;
  logic [PIX_W-1:0]       pix;
  logic [PIX_W-1:0]       dark_pix;
  logic [2:0]             shift_eff;
  logic [7:0]             inv_alpha;
  logic [4:0]             blend_r;
  logic [5:0]             blend_g;
  logic [4:0]             blend_b;

  // Truncating divide by 255 for products below 2^14
  function automatic logic [5:0] div255(input logic [13:0] x);
    logic [14:0] y;
    y = {1'b0, x} + {9'd0, x[13:8]} + 15'd1;
    return y[13:8];
  endfunction

  // Pair store; read address tracks the entry after the head
  rspd_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(PAIR_DEPTH)
  ) u_pair_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(q_entry.payload),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = ptr_inc(rd_ptr_nxt);
  assign next_pair = byp_r ? byp_data_r : ram_rdata;

  assign out_free = !out_valid_r || out_tready;
  assign take     = q_valid && ((q_entry.op != OP_PIXEL) || out_free);
  assign q_pop    = take;
  assign pix      = q_entry.payload[PIX_W-1:0];

  // Clamp row width
  always_comb begin
    if (cfg.line_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (cfg.line_width > MAX_WIDTH_VAL) begin
      width_eff = MAX_WIDTH_VAL;
    end else begin
      width_eff = cfg.line_width;
    end
  end

  // Darken one pixel by the current mode
  always_comb begin
    shift_eff = (cfg.dark_shift > MAX_SHIFT) ? MAX_SHIFT : cfg.dark_shift;
    inv_alpha = 8'd255 - cfg.shadow_alpha;
    blend_r   = 5'(div255(14'(pix[15:11] * inv_alpha)));
    blend_g   = div255(14'(pix[10:5] * inv_alpha));
    blend_b   = 5'(div255(14'(pix[4:0] * inv_alpha)));
    unique case (mode_t'(cfg.dark_mode))
      MODE_BLACK: dark_pix = '0;
      MODE_SHIFT: dark_pix = (pix >> shift_eff) & shift_mask(shift_eff);
      MODE_BLEND: dark_pix = {blend_r, blend_g, blend_b};
      MODE_PASS:  dark_pix = pix;
      default:    dark_pix = pix;
    endcase
  end

  // Execute one queued request
  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    expect_nxt     = expect_r;
    skip_nxt       = skip_r;
    shade_nxt      = shade_r;
    col_nxt        = col_r;
    head_nxt       = head_r;
    ram_we         = 1'b0;
    skip_cur       = skip_r;
    shade_cur      = shade_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_pixel_nxt  = out_pixel_r;
    out_shadow_nxt = out_shadow_r;
    out_last_nxt   = out_last_r;
    if (take) begin
      unique case (q_entry.op) inside
        OP_HEADER: begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          fill_nxt   = '0;
          skip_nxt   = '0;
          shade_nxt  = '0;
          col_nxt    = '0;
          expect_nxt = q_entry.payload[PCOUNT_W-1:0];
        end
        OP_PAIR, OP_EMPTY_PAIR: begin
          if (expect_r != '0) begin
            expect_nxt = expect_r - 1'b1;
            if ((q_entry.op == OP_PAIR) && (fill_r < PAIR_FILL_W'(PAIR_DEPTH))) begin
              ram_we     = 1'b1;
              wr_ptr_nxt = ptr_inc(wr_ptr_r);
              fill_nxt   = fill_r + 1'b1;
              if (fill_r == '0) begin
                head_nxt = q_entry.payload;
              end
            end
          end
        end
        OP_PIXEL: begin
          // Load the next run pair when both runs are spent
          if ((skip_r == '0) && (shade_r == '0) && (fill_r != '0)) begin
            skip_cur   = head_r[PAIR_W-1:CNT_W];
            shade_cur  = head_r[CNT_W-1:0];
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            fill_nxt   = fill_r - 1'b1;
            head_nxt   = next_pair;
          end
          out_valid_nxt  = 1'b1;
          out_pixel_nxt  = pix;
          out_shadow_nxt = 1'b0;
          skip_nxt       = skip_cur;
          shade_nxt      = shade_cur;
          if (skip_cur != '0) begin
            skip_nxt = skip_cur - 1'b1;
          end else if (shade_cur != '0) begin
            shade_nxt      = shade_cur - 1'b1;
            out_shadow_nxt = 1'b1;
            out_pixel_nxt  = dark_pix;
          end
          // Row end clears the row state and clips open runs
          out_last_nxt = (({1'b0, col_r} + WIDTH_W'(1)) >= width_eff);
          if (out_last_nxt) begin
            rd_ptr_nxt = '0;
            wr_ptr_nxt = '0;
            fill_nxt   = '0;
            skip_nxt   = '0;
            shade_nxt  = '0;
            col_nxt    = '0;
            expect_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_tready;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      expect_r    <= '0;
      skip_r      <= '0;
      shade_r     <= '0;
      col_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      expect_r    <= expect_nxt;
      skip_r      <= skip_nxt;
      shade_r     <= shade_nxt;
      col_r       <= col_nxt;
      byp_r       <= ram_we && (wr_ptr_r == ram_raddr);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    byp_data_r   <= q_entry.payload;
    out_pixel_r  <= out_pixel_nxt;
    out_shadow_r <= out_shadow_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = out_shadow_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* rtl/rle_shadow_pixel_darkener.sv */
// Shadow pixel darkener: RLE shadow runs applied to an RGB565 pixel stream.
// Input stream: kind in in_tuser; header, run pair and pixel requests share
//   in_tdata. A header sets the row's pair count, pairs fill a 64-entry
//   store, and each pixel request gives exactly one output request.
// Output stream: pixel in out_tdata, shadow flag in out_tuser, last pixel
//   of the row on out_tlast. Headers, pairs and kind three give no output.
// Config: cfg_index selects dark_mode, dark_shift, shadow_alpha or
//   line_width; always ready, to be written while the stream is idle.
// Throughput: one request per cycle unless out_tready stalls; the back end
//   runs one queued request per cycle, prefetching from the pair store.
// Path of a pixel: it is written into the four-entry queue, then executed
//   from the queue head into the output register that drives out_tvalid.
// Reset (rst_n low, synchronous) empties the queue and the pair store,
//   clears run counters and the column, and loads the register defaults.
// Receiver stall: the output register holds its request; the queue soaks
//   up to four more, then in_tready drops.
`default_nettype none

module rle_shadow_pixel_darkener
  import rspd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: pair_count[6:0], trans_count[18:7], shadow_count[30:19],
  //           dest_pixel[46:31], zero[47]
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  // in_tuser: kind[1:0]
  input  wire logic [1:0]           in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // out_tdata: out_pixel[15:0]
  output logic [PIX_W-1:0]          out_tdata,
  // out_tuser: in_shadow[0]
  output logic                      out_tuser,
  output logic                      out_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [WIDTH_W-1:0]   cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full;
  logic  q_push;
  qent_t q_push_entry;
  logic  q_pop;
  logic  q_valid;
  qent_t q_head;

  assign cfg_ready = 1'b1;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DARK_MODE:    cfg_nxt.dark_mode    = cfg_data[1:0];
        REG_DARK_SHIFT:   cfg_nxt.dark_shift   = cfg_data[2:0];
        REG_SHADOW_ALPHA: cfg_nxt.shadow_alpha = cfg_data[7:0];
        REG_LINE_WIDTH:   cfg_nxt.line_width   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_mode    <= MODE_BLACK;
      cfg_r.dark_shift   <= 3'd1;
      cfg_r.shadow_alpha <= 8'd128;
      cfg_r.line_width   <= WIDTH_W'(640);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rspd_front u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  rspd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_entry(q_head)
  );

  rspd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

/* rtl/rspd_checker.sv */
// Port-level checker for the shadow pixel darkener, bound to the top level.
// Depends on rspd_pkg and rle_shadow_pixel_darkener_macros.svh.
`default_nettype none
`include "rle_shadow_pixel_darkener_macros.svh"

module rspd_port_checker
  import rspd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tready,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [PIX_W-1:0]     out_tdata,
  input wire logic                 out_tuser,
  input wire logic                 out_tlast
);

  // A stalled output request holds
  `RSPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // The input side backs up only behind a stalled output
  `RSPD_ASSERT_NOW(a_in_backpressure, clk, rst_n, !in_tready,
    $past(out_tvalid && !out_tready))

  // No output request right after reset
  `RSPD_ASSERT_NOW(a_reset_empty, clk, rst_n, $rose(rst_n), !out_tvalid)

endmodule

bind rle_shadow_pixel_darkener rspd_port_checker u_rspd_checker (.*);

`default_nettype wire

/* dv/rspd_checker.sv */
// Checker for the shadow pixel darkener: follows the config, input and output
// channels, predicts every output pixel and compares it field by field.
// Depends on rspd_pkg for widths, kinds, modes and register indexes.

module rspd_checker
  import rspd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]           in_tuser,
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [PIX_W-1:0]     out_tdata,
  input  wire logic                 out_tuser,
  input  wire logic                 out_tlast,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [WIDTH_W-1:0]   cfg_data,
  output int unsigned               fail_count,
  output int unsigned               pending
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             shadow;
    logic             last;
  } shaded_pixel_t;

  // Pixels predicted but not yet seen on the output
  shaded_pixel_t due_pixels[$];

  // Shadow copy of the registers
  mode_t              mode_r;
  logic [2:0]         shift_r;
  logic [7:0]         alpha_r;
  logic [WIDTH_W-1:0] width_r;

  // Shadow copy of the run state
  logic [PAIR_W-1:0]   run_pairs [PAIR_DEPTH];
  int                  rd_ptr;
  int                  wr_ptr;
  int                  fill;
  logic [PCOUNT_W-1:0] pairs_left;
  logic [CNT_W-1:0]    skip_cnt;
  logic [CNT_W-1:0]    shade_cnt;
  logic [COL_W-1:0]    col;

  int unsigned errs = 0;

  assign fail_count = errs;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
    errs++;
    $display("%0t rspd_checker: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Darken one pixel by the current mode
  function automatic logic [PIX_W-1:0] darken_pixel(input logic [PIX_W-1:0] p);
    int amt;
    int inv;
    int r;
    int g;
    int b;
    logic [PIX_W-1:0] res;
    case (mode_r)
      MODE_BLACK: res = '0;
      MODE_SHIFT: begin
        // shift each channel on its own so no bit crosses into a neighbor
        amt = (shift_r > 3'd4) ? 4 : int'(shift_r);
        r = int'(p[15:11]) >> amt;
        g = int'(p[10:5]) >> amt;
        b = int'(p[4:0]) >> amt;
        res = PIX_W'((r << 11) | (g << 5) | b);
      end
      MODE_BLEND: begin
        inv = 255 - int'(alpha_r);
        r = (int'(p[15:11]) * inv) / 255;
        g = (int'(p[10:5]) * inv) / 255;
        b = (int'(p[4:0]) * inv) / 255;
        res = PIX_W'((r << 11) | (g << 5) | b);
      end
      default: res = p;
    endcase
    return res;
  endfunction

  task automatic clear_row();
    rd_ptr    = 0;
    wr_ptr    = 0;
    fill      = 0;
    skip_cnt  = '0;
    shade_cnt = '0;
    col       = '0;
  endtask

  // Advance the run state by one accepted request; pixels queue a prediction
  task automatic advance_row(input logic [1:0] k, input logic [IN_DATA_W-1:0] d);
    logic [CNT_W-1:0] t;
    logic [CNT_W-1:0] s;
    int               w;
    shaded_pixel_t    res;
    t = d[18:7];
    s = d[30:19];
    case (kind_t'(k))
      KIND_HEADER: begin
        clear_row();
        pairs_left = d[6:0];
      end
      KIND_PAIR: begin
        // drop surplus pairs; empty ones still use up the count
        if (pairs_left != '0) begin
          pairs_left--;
          if ((t != '0 || s != '0) && fill < PAIR_DEPTH) begin
            run_pairs[wr_ptr] = {t, s};
            wr_ptr = (wr_ptr + 1) % PAIR_DEPTH;
            fill++;
          end
        end
      end
      KIND_PIXEL: begin
        w = (width_r == '0) ? 1 : (width_r > MAX_WIDTH) ? MAX_WIDTH : int'(width_r);
        // fetch the next pair once the current one is used up
        if (skip_cnt == '0 && shade_cnt == '0 && fill > 0) begin
          {skip_cnt, shade_cnt} = run_pairs[rd_ptr];
          rd_ptr = (rd_ptr + 1) % PAIR_DEPTH;
          fill--;
        end
        res.pixel  = d[46:31];
        res.shadow = 1'b0;
        if (skip_cnt != '0) begin
          skip_cnt--;
        end else if (shade_cnt != '0) begin
          shade_cnt--;
          res.shadow = 1'b1;
          res.pixel  = darken_pixel(d[46:31]);
        end
        // clip runs at the row end
        res.last = (int'(col) + 1 >= w);
        if (res.last) begin
          clear_row();
          pairs_left = '0;
        end else begin
          col++;
        end
        due_pixels.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Follow all three channels at each edge
  always @(posedge clk) begin : watch
    shaded_pixel_t head;
    if (!rst_n) begin
      mode_r     = MODE_BLACK;
      shift_r    = 3'd1;
      alpha_r    = 8'd128;
      width_r    = WIDTH_W'(640);
      pairs_left = '0;
      clear_row();
      due_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_DARK_MODE:    mode_r  = mode_t'(cfg_data[1:0]);
          REG_DARK_SHIFT:   shift_r = cfg_data[2:0];
          REG_SHADOW_ALPHA: alpha_r = cfg_data[7:0];
          REG_LINE_WIDTH:   width_r = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_row(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (due_pixels.size() == 0) begin
          report_mismatch("output request with no pixel due", '0, out_tdata);
        end else begin
          head = due_pixels.pop_front();
          if (out_tdata !== head.pixel) begin
            report_mismatch("pixel", head.pixel, out_tdata);
          end
          if (out_tuser !== head.shadow) begin
            report_mismatch("shadow flag", PIX_W'(head.shadow), PIX_W'(out_tuser));
          end
          if (out_tlast !== head.last) begin
            report_mismatch("row end", PIX_W'(head.last), PIX_W'(out_tlast));
          end
        end
      end
    end
    pending <= due_pixels.size();
  end

endmodule

/* dv/tb_rle_shadow_pixel_darkener.sv */
// Testbench top for the shadow pixel darkener: drives rows of headers, run
// pairs and pixels under several register settings and gives the verdict.
// Depends on rspd_pkg, the block itself and rspd_checker.

module tb_rle_shadow_pixel_darkener;
  import rspd_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_ITEMS  = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int FIXED_PHASES = 9;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [1:0]           in_tuser   = '0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [1:0]           cfg_index  = '0;
  logic [WIDTH_W-1:0]   cfg_data   = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [PIX_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_ready;
  int unsigned          fail_count;
  int unsigned          pending_pixels;

  logic steady      = 1'b0;
  int   items_sent  = 0;
  int   cur_width   = 640;
  int   quiet_count = 0;

  // Fixed settings first: extremes of every register, then random ones
  mode_t set_mode  [FIXED_PHASES] = '{MODE_SHIFT, MODE_BLACK, MODE_SHIFT, MODE_BLEND,
                                      MODE_BLEND, MODE_PASS, MODE_SHIFT, MODE_BLEND,
                                      MODE_SHIFT};
  int    set_shift [FIXED_PHASES] = '{7, 0, 4, 3, 5, 6, 2, 1, 0};
  int    set_alpha [FIXED_PHASES] = '{0, 255, 77, 0, 255, 200, 128, 1, 254};
  int    set_width [FIXED_PHASES] = '{4, 1, 8, 13, 0, 6, 4096, 8191, 32};

  rle_shadow_pixel_darkener u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rspd_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending_pixels)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the receiver at random, except in the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 17);
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= STALL_LIMIT) begin
      $display("tb_rle_shadow_pixel_darkener: FAIL");
      $finish;
    end
  end

  // Pack fields into in_tdata, lowest field first
  function automatic logic [IN_DATA_W-1:0] pack_req(input logic [PCOUNT_W-1:0] pc,
                                                    input logic [CNT_W-1:0] t,
                                                    input logic [CNT_W-1:0] s,
                                                    input logic [PIX_W-1:0] p);
    return {1'b0, p, s, t, pc};
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Offer one request, after a random gap unless steady, and hold it until accepted
  task automatic push_request(input kind_t k, input logic [IN_DATA_W-1:0] d);
    if (!steady) begin
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (k != KIND_NONE) items_sent++;
  endtask

  task automatic send_header(input int pc);
    push_request(KIND_HEADER, pack_req(PCOUNT_W'(pc), CNT_W'($urandom), CNT_W'($urandom),
                                       PIX_W'($urandom)));
  endtask

  task automatic send_pair(input int t, input int s);
    push_request(KIND_PAIR, pack_req(PCOUNT_W'($urandom), CNT_W'(t), CNT_W'(s),
                                     PIX_W'($urandom)));
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    push_request(KIND_PIXEL, pack_req(PCOUNT_W'($urandom), CNT_W'($urandom),
                                      CNT_W'($urandom), p));
  endtask

  task automatic send_junk();
    push_request(KIND_NONE, pack_req(PCOUNT_W'($urandom), CNT_W'($urandom),
                                     CNT_W'($urandom), PIX_W'($urandom)));
  endtask

  // Hold the sender until every predicted pixel has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= WIDTH_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input mode_t m, input int sh, input int a, input int w);
    wait_drained();
    // let headers and pairs still queued inside settle before any write
    repeat (10) @(posedge clk);
    write_reg(REG_DARK_MODE, m);
    write_reg(REG_DARK_SHIFT, sh);
    write_reg(REG_SHADOW_ALPHA, a);
    write_reg(REG_LINE_WIDTH, w);
    cfg_valid <= 1'b0;
    cur_width = w;
  endtask

  // One row: header, pairs, pixels; sometimes surplus, short or overlong
  task automatic gen_row(input int w);
    int pc;
    int n_pairs;
    int npix;
    int span;
    int r;
    r = $urandom_range(99);
    pc = (r < 55) ? $urandom_range(3) : (r < 80) ? $urandom_range(12, 4) :
         (r < 95) ? $urandom_range(64, 13) : $urandom_range(127, 65);
    r = $urandom_range(9);
    n_pairs = (r == 0) ? pc + $urandom_range(3, 1) : (r == 1) ? $urandom_range(pc) : pc;
    span = (w > 64) ? 40 : w / 2 + 1;
    send_header(pc);
    for (int i = 0; i < n_pairs; i++) begin
      case ($urandom_range(11))
        0:       send_pair(0, 0);
        1:       send_pair(4095, 4095);
        2:       send_pair($urandom_range(4095), $urandom_range(4095));
        default: send_pair($urandom_range(span), $urandom_range(span, 1));
      endcase
    end
    if (w > 64) begin
      npix = $urandom_range(40, 1);
    end else begin
      r = $urandom_range(9);
      npix = (r == 0) ? $urandom_range(w, 1) : (r == 1) ? w + $urandom_range(w, 1) : w;
    end
    for (int i = 0; i < npix; i++) begin
      // sprinkle stray requests among the pixels
      if ($urandom_range(49) == 0) begin
        if ($urandom_range(1) == 1) begin
          send_junk();
        end else begin
          send_pair($urandom_range(span), $urandom_range(span));
        end
      end
      send_pixel(pick_pixel());
    end
  endtask

  initial begin : stimulus
    int goal;
    int phase_end;
    int w;
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty and surplus pairs, headerless row, ignored kind,
    // mid-row restart and a run clipped at the row end
    configure(set_mode[0], set_shift[0], set_alpha[0], set_width[0]);
    send_header(2);
    send_pair(1, 2);
    send_pair(0, 0);
    send_pair(3, 3);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h1234);
    repeat (4) send_pixel(16'hFFFF);
    send_junk();
    send_header(1);
    send_pair(4095, 4095);
    send_pixel(16'hF81F);
    send_pixel(16'h07E0);
    send_header(64);
    send_pair(0, 4095);
    repeat (4) send_pixel(pick_pixel());

    // Random rows, one batch per register setting
    goal  = items_sent + RANDOM_ITEMS;
    phase = 1;
    while (items_sent < goal) begin
      if (phase < FIXED_PHASES) begin
        configure(set_mode[phase], set_shift[phase], set_alpha[phase], set_width[phase]);
      end else begin
        configure(mode_t'($urandom_range(3)), $urandom_range(7), $urandom_range(255),
                  ($urandom_range(4) == 0) ? 64 : $urandom_range(40, 1));
      end
      steady <= (phase == 3);
      w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < goal) gen_row(w);
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d register settings, all dark modes and shifts,",
             items_sent, phase);
    $display("widths 0 to 8191, clipped runs, surplus pairs and store overflow");
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("tb_rle_shadow_pixel_darkener: PASS");
    end else begin
      $display("tb_rle_shadow_pixel_darkener: FAIL");
    end
    $finish;
  end

endmodule
